>>> design/gfm_pkg.sv
// Shared types and constants for the gcd Fibonacci residue core.
package gfm_pkg;

  // Depth of the request queue between front and back.
  localparam int unsigned QueueDepth = 2;

  // Front classification of a request.
  typedef enum logic [1:0] {
    KIND_ONE,
    KIND_ZERO,
    KIND_FIB
  } kind_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_RUN,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_STEP,
    B_ISSUE,
    B_MUL,
    B_COMMIT,
    B_FINAL,
    B_OUT
  } back_state_e;

endpackage

>>> design/gfm_front.sv
// Front: accepts requests, runs a binary gcd and classifies the result.
module gfm_front #(
  parameter int unsigned OperandBits = 30
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [OperandBits-1:0] first_index_i,
  input  logic [OperandBits-1:0] second_index_i,
  input  logic [OperandBits-1:0] modulus_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   full_i,
  output logic                   push_o,
  output gfm_pkg::kind_e         push_kind_o,
  output logic [OperandBits:0]   push_exp_o,
  output logic [OperandBits-1:0] push_mod_o
);
  localparam int unsigned IdxBits = OperandBits + 1;
  localparam int unsigned ShBits  = $clog2(IdxBits + 1);

  gfm_pkg::front_state_e state_q, state_d;
  logic [IdxBits-1:0]     a_q, a_d, b_q, b_d;
  logic [OperandBits-1:0] p_q, p_d;
  logic [ShBits-1:0]      s_q, s_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gfm_pkg::F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    p_q <= p_d;
    s_q <= s_d;
  end

  always_comb begin
    state_d    = state_q;
    a_d        = a_q;
    b_d        = b_q;
    p_d        = p_q;
    s_d        = s_q;
    in_ready_o = 1'b0;
    push_o     = 1'b0;
    unique case (state_q)
      gfm_pkg::F_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          a_d     = {1'b0, first_index_i} + IdxBits'(2);
          b_d     = {1'b0, second_index_i} + IdxBits'(2);
          p_d     = modulus_i;
          s_d     = '0;
          state_d = gfm_pkg::F_RUN;
        end
      end
      gfm_pkg::F_RUN: begin
        if (a_q == b_q) begin
          // restore the common power of two; a_q now holds the gcd
          a_d     = a_q << s_q;
          state_d = gfm_pkg::F_PUSH;
        end else if (!a_q[0] && !b_q[0]) begin
          a_d = a_q >> 1;
          b_d = b_q >> 1;
          s_d = s_q + ShBits'(1);
        end else if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (a_q > b_q) begin
          a_d = a_q - b_q;
        end else begin
          b_d = b_q - a_q;
        end
      end
      gfm_pkg::F_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = gfm_pkg::F_IDLE;
        end
      end
      default: state_d = gfm_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    if (a_q <= IdxBits'(2)) begin
      push_kind_o = gfm_pkg::KIND_ONE;
    end else if (p_q == '0) begin
      push_kind_o = gfm_pkg::KIND_ZERO;
    end else begin
      push_kind_o = gfm_pkg::KIND_FIB;
    end
  end

  assign push_exp_o = a_q - IdxBits'(2);
  assign push_mod_o = p_q;

endmodule

>>> design/gfm_queue.sv
// Short request queue between front and back.
module gfm_queue #(
  parameter int unsigned DataBits = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [DataBits-1:0] push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic [DataBits-1:0] pop_data_o,
  output logic                empty_o
);
  localparam int unsigned Depth   = gfm_pkg::QueueDepth;
  localparam int unsigned PtrBits = $clog2(Depth);
  localparam int unsigned CntBits = $clog2(Depth + 1);

  logic [DataBits-1:0] mem_q [Depth];
  logic [PtrBits-1:0]  wr_q, rd_q;
  logic [CntBits-1:0]  cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + PtrBits'(1);
      if (pop_i)  rd_q <= rd_q + PtrBits'(1);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntBits'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  assign pop_data_o = mem_q[rd_q];
  assign full_o     = (cnt_q == CntBits'(Depth));
  assign empty_o    = (cnt_q == '0);

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntBits'(Depth)) else $error("queue count out of range");

endmodule

>>> design/gfm_modmul.sv
// Bit-serial modular multiplier: a*b mod p, one bit of b per cycle.
module gfm_modmul #(
  parameter int unsigned OperandBits = 30
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [OperandBits-1:0] a_i,
  input  logic [OperandBits-1:0] b_i,
  input  logic [OperandBits-1:0] p_i,
  output logic                   done_o,
  output logic [OperandBits-1:0] prod_o
);
  localparam int unsigned W       = OperandBits;
  localparam int unsigned CntBits = $clog2(W);

  logic               busy_q, busy_d, done_q, done_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic [W-1:0]       a_q, a_d, b_q, b_d, p_q, p_d, r_q, r_d;
  logic [W:0]         dbl, dbl_red, sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    a_q   <= a_d;
    b_q   <= b_d;
    p_q   <= p_d;
    r_q   <= r_d;
  end

  always_comb begin
    // r stays below p: double, reduce, add, reduce
    dbl     = {r_q, 1'b0};
    dbl_red = (dbl >= {1'b0, p_q}) ? dbl - {1'b0, p_q} : dbl;
    sum     = dbl_red + (b_q[W-1] ? {1'b0, a_q} : '0);
    if (sum >= {1'b0, p_q}) sum = sum - {1'b0, p_q};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    p_d    = p_q;
    r_d    = r_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      a_d    = a_i;
      b_d    = b_i;
      p_d    = p_i;
      r_d    = '0;
    end else if (busy_q) begin
      r_d   = sum[W-1:0];
      b_d   = b_q << 1;
      cnt_d = cnt_q + CntBits'(1);
      if (cnt_q == CntBits'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = r_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("multiplier restarted while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_q)) else $error("multiplier done without work");

endmodule

>>> design/gfm_back.sv
// Back: Fibonacci matrix power modulo p by square-and-multiply.
module gfm_back #(
  parameter int unsigned OperandBits = 30
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   empty_i,
  output logic                   pop_o,
  input  gfm_pkg::kind_e         kind_i,
  input  logic [OperandBits:0]   exp_i,
  input  logic [OperandBits-1:0] mod_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OperandBits-1:0] residue_o
);
  localparam int unsigned W = OperandBits;

  gfm_pkg::back_state_e state_q, state_d;
  logic [W-1:0] acc_q [4];
  logic [W-1:0] acc_d [4];
  logic [W-1:0] base_q [4];
  logic [W-1:0] base_d [4];
  logic [W-1:0] nm_q [4];
  logic [W-1:0] nm_d [4];
  logic [W:0]   e_q, e_d;
  logic [W-1:0] p_q, p_d, t_q, t_d, res_q, res_d;
  logic [2:0]   idx_q, idx_d;
  logic         sq_q, sq_d, did_acc_q, did_acc_d, fib_q, fib_d;
  logic         mul_start, mul_done;
  logic [W-1:0] mul_a, mul_b, mul_prod, one_p;

  function automatic logic [W-1:0] add_mod(input logic [W-1:0] x,
                                           input logic [W-1:0] y,
                                           input logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[W-1:0];
  endfunction

  gfm_modmul #(.OperandBits(W)) u_modmul (
    .clk_i,
    .rst_ni,
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .p_i     (p_q),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gfm_pkg::B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    base_q    <= base_d;
    nm_q      <= nm_d;
    e_q       <= e_d;
    p_q       <= p_d;
    t_q       <= t_d;
    res_q     <= res_d;
    idx_q     <= idx_d;
    sq_q      <= sq_d;
    did_acc_q <= did_acc_d;
    fib_q     <= fib_d;
  end

  // product term idx[0] of entry (idx[2], idx[1])
  assign mul_a = sq_q ? base_q[{idx_q[2], idx_q[0]}] : acc_q[{idx_q[2], idx_q[0]}];
  assign mul_b = base_q[{idx_q[0], idx_q[1]}];
  assign one_p = (mod_i == W'(1)) ? '0 : W'(1);

  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    base_d      = base_q;
    nm_d        = nm_q;
    e_d         = e_q;
    p_d         = p_q;
    t_d         = t_q;
    res_d       = res_q;
    idx_d       = idx_q;
    sq_d        = sq_q;
    did_acc_d   = did_acc_q;
    fib_d       = fib_q;
    pop_o       = 1'b0;
    mul_start   = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      gfm_pkg::B_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          p_d   = mod_i;
          fib_d = 1'b0;
          unique case (kind_i)
            gfm_pkg::KIND_ONE: begin
              res_d   = W'(1);
              state_d = gfm_pkg::B_OUT;
            end
            gfm_pkg::KIND_ZERO: begin
              res_d   = '0;
              state_d = gfm_pkg::B_OUT;
            end
            default: begin
              fib_d     = 1'b1;
              e_d       = exp_i;
              did_acc_d = 1'b0;
              acc_d     = '{one_p, '0, '0, one_p};
              base_d    = '{one_p, one_p, one_p, '0};
              state_d   = gfm_pkg::B_STEP;
            end
          endcase
        end
      end
      gfm_pkg::B_STEP: begin
        idx_d = '0;
        if (e_q == '0) begin
          state_d = gfm_pkg::B_FINAL;
        end else begin
          sq_d    = !(e_q[0] && !did_acc_q);
          state_d = gfm_pkg::B_ISSUE;
        end
      end
      gfm_pkg::B_ISSUE: begin
        mul_start = 1'b1;
        state_d   = gfm_pkg::B_MUL;
      end
      gfm_pkg::B_MUL: begin
        if (mul_done) begin
          if (!idx_q[0]) begin
            t_d = mul_prod;
          end else begin
            nm_d[idx_q[2:1]] = add_mod(t_q, mul_prod, p_q);
          end
          if (idx_q == 3'd7) begin
            state_d = gfm_pkg::B_COMMIT;
          end else begin
            idx_d   = idx_q + 3'd1;
            state_d = gfm_pkg::B_ISSUE;
          end
        end
      end
      gfm_pkg::B_COMMIT: begin
        if (sq_q) begin
          base_d    = nm_q;
          did_acc_d = 1'b0;
          e_d       = e_q >> 1;
        end else begin
          acc_d     = nm_q;
          did_acc_d = 1'b1;
        end
        state_d = gfm_pkg::B_STEP;
      end
      gfm_pkg::B_FINAL: begin
        res_d   = add_mod(acc_q[0], acc_q[1], p_q);
        state_d = gfm_pkg::B_OUT;
      end
      gfm_pkg::B_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = gfm_pkg::B_IDLE;
      end
      default: state_d = gfm_pkg::B_IDLE;
    endcase
  end

  assign residue_o = res_q;

  a_residue_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fib_q) |-> (residue_o < p_q))
    else $error("residue not reduced");

endmodule

>>> design/gcd_fibonacci_mod_core.sv
// Top level: F(gcd(n+2, m+2)) mod p with decoupled gcd front and matrix back.
//
//   channel   signals                                        direction
//   request   in_valid_i / in_ready_o, first_index_i,
//             second_index_i, modulus_i                      in
//   result    out_valid_o / out_ready_i, residue_o           out
//
// The front runs a binary gcd per request, one step a cycle. The back
// needs per exponent bit up to two 2x2 matrix products of 8 serial
// modular multiplies each, all on the single bit-serial multiplier.
// Reset clears all control state; a two-entry queue lets the front work
// on the next request while the back computes or its result waits.
module gcd_fibonacci_mod_core #(
  parameter int unsigned OPERAND_BITS = 30
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [OPERAND_BITS-1:0] first_index_i,
  input  logic [OPERAND_BITS-1:0] second_index_i,
  input  logic [OPERAND_BITS-1:0] modulus_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [OPERAND_BITS-1:0] residue_o
);
  localparam int unsigned W        = OPERAND_BITS;
  localparam int unsigned KindBits = $bits(gfm_pkg::kind_e);
  localparam int unsigned DataBits = KindBits + (W + 1) + W;

  logic                push, pop, full, empty;
  gfm_pkg::kind_e      push_kind;
  logic [W:0]          push_exp;
  logic [W-1:0]        push_mod;
  logic [DataBits-1:0] pop_data;

  gfm_front #(.OperandBits(W)) u_front (
    .clk_i,
    .rst_ni,
    .first_index_i,
    .second_index_i,
    .modulus_i,
    .in_valid_i,
    .in_ready_o,
    .full_i      (full),
    .push_o      (push),
    .push_kind_o (push_kind),
    .push_exp_o  (push_exp),
    .push_mod_o  (push_mod)
  );

  gfm_queue #(.DataBits(DataBits)) u_queue (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_data_i ({push_kind, push_exp, push_mod}),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  gfm_back #(.OperandBits(W)) u_back (
    .clk_i,
    .rst_ni,
    .empty_i     (empty),
    .pop_o       (pop),
    .kind_i      (gfm_pkg::kind_e'(pop_data[DataBits-1 -: KindBits])),
    .exp_i       (pop_data[W +: W + 1]),
    .mod_i       (pop_data[W-1:0]),
    .out_valid_o,
    .out_ready_i,
    .residue_o
  );

endmodule

>>> verif/gcd_fibonacci_mod_core_checker.sv
// Checker: watches both channels, predicts residues and compares them in order.
`timescale 1ns / 1ps
module gcd_fibonacci_mod_core_checker #(
  parameter int unsigned OPERAND_BITS = 30
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic [OPERAND_BITS-1:0] first_index_i,
  input  logic [OPERAND_BITS-1:0] second_index_i,
  input  logic [OPERAND_BITS-1:0] modulus_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic [OPERAND_BITS-1:0] residue_i,
  output int                      errors_o,
  output int                      pending_o,
  output int                      results_o
);

  typedef logic [63:0] word_t;
  typedef word_t mat_t [4];

  logic [OPERAND_BITS-1:0] residue_q [$];

  function automatic void mat_mul(input mat_t x, input mat_t y, input word_t p,
                                  output mat_t r);
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        r[2*i+j] = ((x[2*i] * y[j]) % p + (x[2*i+1] * y[2+j]) % p) % p;
      end
    end
  endfunction

  function automatic logic [OPERAND_BITS-1:0] fib_residue(
      input logic [OPERAND_BITS-1:0] n, input logic [OPERAND_BITS-1:0] m,
      input logic [OPERAND_BITS-1:0] pm);
    word_t a, b, t, p, e;
    mat_t acc, base, tmp;
    a = word_t'(n) + 2;
    b = word_t'(m) + 2;
    p = word_t'(pm);
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    if (a <= 2) return OPERAND_BITS'(1);
    if (p == 0) return '0;
    acc = '{1 % p, 0, 0, 1 % p};
    base = '{1 % p, 1 % p, 1 % p, 0};
    e = a - 2;
    while (e != 0) begin
      if (e[0]) begin
        mat_mul(acc, base, p, tmp);
        acc = tmp;
      end
      mat_mul(base, base, p, tmp);
      base = tmp;
      e = e >> 1;
    end
    return OPERAND_BITS'((acc[0] + acc[1]) % p);
  endfunction

  assign pending_o = residue_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      errors_o  <= 0;
      results_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        residue_q.push_back(fib_residue(first_index_i, second_index_i, modulus_i));
      end
      if (out_valid_i && out_ready_i) begin
        results_o <= results_o + 1;
        if (residue_q.size() == 0) begin
          $error("residue: unexpected result %0d", residue_i);
          errors_o <= errors_o + 1;
        end else begin
          if (residue_q[0] !== residue_i) begin
            $error("residue: expected %0d, actual %0d", residue_q[0], residue_i);
            errors_o <= errors_o + 1;
          end
          void'(residue_q.pop_front());
        end
      end
    end
  end

endmodule

>>> verif/gcd_fibonacci_mod_core_tb.sv
// Testbench top: drives requests and result stalls, gives the verdict.
`timescale 1ns / 1ps
module gcd_fibonacci_mod_core_tb;

  localparam int unsigned W = 30;
  localparam int unsigned NumRandom = 300;
  localparam int unsigned WatchLimit = 400000;
  localparam logic [W-1:0] MaxVal = {W{1'b1}};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [W-1:0] first_index = '0, second_index = '0, modulus = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [W-1:0] residue;
  int errors, pending, results;
  int sent = 0;
  bit quiet = 1'b0;
  bit hold_off = 1'b0;
  bit stim_done = 1'b0;
  int idle_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  gcd_fibonacci_mod_core #(.OPERAND_BITS(W)) u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .first_index_i(first_index), .second_index_i(second_index), .modulus_i(modulus),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .residue_o(residue)
  );

  gcd_fibonacci_mod_core_checker #(.OPERAND_BITS(W)) u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .first_index_i(first_index), .second_index_i(second_index), .modulus_i(modulus),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .residue_i(residue),
    .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  // Valid stays up from one request to the next unless a gap drops it.
  task automatic send_request(input logic [W-1:0] n, input logic [W-1:0] m,
                              input logic [W-1:0] p);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    first_index  <= n;
    second_index <= m;
    modulus      <= p;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // Indices that share a factor g after the +2 shift, so the gcd is large.
  task automatic send_shared(input logic [W-1:0] g, input logic [W-1:0] p);
    logic [W-1:0] a, b;
    int unsigned lim;
    lim = (g > 1) ? (32'(MaxVal) / 32'(g)) : 1000;
    if (lim > 5000) lim = 5000;
    a = W'(g * $urandom_range(1, lim) - 2);
    b = W'(g * $urandom_range(1, lim) - 2);
    send_request(a, b, p);
  endtask

  // Result side: random stall bursts, one long hold-off, none at the end.
  always @(posedge clk) begin
    if (!rst_n || hold_off) begin
      out_ready <= 1'b0;
    end else if (quiet || $urandom_range(0, 5) != 0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || hold_off) begin
      idle_cycles <= 0;
    end else if (rst_n && (in_valid || pending != 0 || !stim_done)) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("gcd_fibonacci_mod_core_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    logic [W-1:0] g;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, small gcd, unit and zero modulus, zero indices.
    send_request(W'(1), W'(1), W'(1));
    send_request(W'(1), W'(2), W'(7));
    send_request(W'(4), W'(4), W'(1));
    send_request(W'(4), W'(4), W'(0));
    send_request(W'(0), W'(0), W'(5));
    send_request(W'(0), W'(2), W'(0));
    send_request(W'(8), W'(8), W'(1000));
    send_request(MaxVal, MaxVal, MaxVal);
    send_request(MaxVal, MaxVal, W'(1));
    send_request(MaxVal, W'(1), MaxVal);
    send_request(W'(MaxVal - 1), W'(MaxVal - 1), W'(MaxVal - 2));
    send_request(W'(MaxVal - 1), W'(MaxVal - 1), W'(0));
    send_request(W'(28), W'(58), W'(2));
    send_request(W'(98), W'(48), W'(1000000007 & MaxVal));
    send_request(30'h2AAAAAAA, 30'h15555555, 30'h15555555);
    send_request(30'h15555554, 30'h2AAAAAA9, 30'h2AAAAAAA);
    send_request(W'(1), MaxVal, MaxVal);

    // Long result hold-off while requests keep coming.
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int i = 0; i < 6; i++) send_shared(W'($urandom_range(3, 200)),
                                                W'($urandom_range(2, 1000)));
      end
    join

    for (int i = 0; i < NumRandom; i++) begin
      if (i > NumRandom - 40) quiet = 1'b1;
      case ($urandom_range(0, 5))
        0: send_request(W'($urandom), W'($urandom), W'($urandom));
        1: send_request(W'($urandom), W'($urandom), W'($urandom_range(0, 3)));
        2: send_request(W'($urandom_range(0, 50)), W'($urandom_range(0, 50)),
                        W'($urandom));
        default: begin
          g = ($urandom_range(0, 3) == 0) ? W'($urandom_range(3, 1 << 28))
                                          : W'($urandom_range(3, 5000));
          send_shared(g, W'($urandom));
        end
      endcase
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d requests (directed corners, shared-factor indices, random)",
             sent);
    $display("and checked %0d residues, including a long result hold-off.", results);
    if (errors == 0) begin
      $display("gcd_fibonacci_mod_core_tb: done, clean");
    end else begin
      $display("gcd_fibonacci_mod_core_tb: done, errors");
    end
    $finish;
  end

endmodule
